[sv/overwrite_ring_queue_with_average_defines.svh]
// Assertion macros for the ring queue checker.
// Depends on nothing; included by the checker file.
`ifndef OVERWRITE_RING_QUEUE_WITH_AVERAGE_DEFINES_SVH
`define OVERWRITE_RING_QUEUE_WITH_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ORQA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring queue check failed");

// Next-cycle implication, disabled during reset.
`define ORQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring queue check failed");

`endif

[sv/orqa_pkg.sv]
// Shared types and constants of the ring queue with running year average.
// Depends on nothing.
package orqa_pkg;

  localparam int unsigned TAG_W  = 16;
  localparam int unsigned YEAR_W = 12;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic KIND_AVERAGE = 1'b0;
  localparam logic KIND_REMOVED = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TAG_W-1:0]  item_tag;
    logic [YEAR_W-1:0] item_year;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [YEAR_W-1:0] average_year;
    logic [TAG_W-1:0]  removed_tag;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  item_tag;
    logic [YEAR_W-1:0] item_year;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PUSH,
    S_PREP,
    S_DIV,
    S_OUT
  } state_e;

endpackage

[sv/orqa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module orqa_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 5
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/overwrite_ring_queue_with_average.sv]
// Top level: ring queue that drops its oldest entry when full and reports the
// rounded mean of stored nonzero years. Depends on orqa_pkg and orqa_ram.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// Insert: a full queue first drops its oldest entry (POP); the item is stored
// (PUSH), the division set up (PREP), then the compare-subtract divider gives
// one quotient bit per cycle over 12 steps (DIV); with no nonzero year stored
// DIV is skipped. Remove: the head tag is read in POP and shown in OUT; remove
// on an empty queue gives nothing and the block is ready again in the next cycle.
// One item at a time; out stall holds the result and keeps in_stall_o high.
// Reset clears indices, counts and sums; the entry store needs no clearing.
module overwrite_ring_queue_with_average
  import orqa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = YEAR_W + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + 1;
  localparam int unsigned REM_W  = CNT_W + 2;
  localparam int unsigned STEP_W = $clog2(YEAR_W);
  localparam int unsigned ENT_W  = $bits(entry_t);

  state_e state_q, state_d;

  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d, dated_q, dated_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [YEAR_W-1:0] quo_q, quo_d;
  in_item_t          item_q, item_d;
  out_item_t         res_q, res_d;

  logic             in_acc;
  logic             ram_we;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] trial, den;
  logic             trial_ge;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign rd_entry = entry_t'(ram_rdata);
  assign wr_entry = '{item_tag: item_q.item_tag, item_year: item_q.item_year};

  orqa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.cmd == CMD_REMOVE) begin
            state_d = (count_q == '0) ? S_IDLE : S_POP;
          end else begin
            state_d = (count_q == CNT_W'(QUEUE_DEPTH)) ? S_POP : S_PUSH;
          end
        end
      end
      S_POP:  state_d = (item_q.cmd == CMD_REMOVE) ? S_OUT : S_PUSH;
      S_PUSH: state_d = S_PREP;
      S_PREP: state_d = (dated_q == '0) ? S_OUT : S_DIV;
      S_DIV: begin
        if (step_q == STEP_W'(YEAR_W - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    ram_we      = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o  = 1'b0;
      S_PUSH:  ram_we      = 1'b1;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // shared compare-subtract step
  assign num      = {sum_q, 1'b0} + NUM_W'(dated_q);
  assign trial    = {rem_q[REM_W-2:0], quo_q[YEAR_W-1]};
  assign den      = REM_W'({dated_q, 1'b0});
  assign trial_ge = (trial >= den);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    dated_d = dated_q;
    sum_d   = sum_q;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    item_d  = item_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_item_i;
        end
      end
      S_POP: begin
        if (rd_entry.item_year != '0) begin
          sum_d   = sum_q - SUM_W'(rd_entry.item_year);
          dated_d = dated_q - CNT_W'(1);
        end
        head_d  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        count_d = count_q - CNT_W'(1);
        res_d   = '{result_kind: KIND_REMOVED, average_year: '0,
                    removed_tag: rd_entry.item_tag};
      end
      S_PUSH: begin
        tail_d  = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);
        count_d = count_q + CNT_W'(1);
        if (item_q.item_year != '0) begin
          sum_d   = sum_q + SUM_W'(item_q.item_year);
          dated_d = dated_q + CNT_W'(1);
        end
      end
      S_PREP: begin
        rem_d  = REM_W'(num[NUM_W-1:YEAR_W]);
        quo_d  = num[YEAR_W-1:0];
        step_d = '0;
        res_d  = '{result_kind: KIND_AVERAGE, average_year: '0, removed_tag: '0};
      end
      S_DIV: begin
        rem_d  = trial_ge ? (trial - den) : trial;
        quo_d  = {quo_q[YEAR_W-2:0], trial_ge};
        step_d = step_q + STEP_W'(1);
        res_d  = '{result_kind: KIND_AVERAGE, average_year: quo_d, removed_tag: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      dated_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      dated_q <= dated_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_item_o = res_q;

endmodule

[sv/orqa_checker.sv]
// Port-level checks of the ring queue, bound to the top level.
// Depends on orqa_pkg and overwrite_ring_queue_with_average_defines.svh.
`include "overwrite_ring_queue_with_average_defines.svh"

module orqa_checker
  import orqa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `ORQA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `ORQA_ASSERT_SAME(a_one_item, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ORQA_ASSERT_NEXT(a_ready_after_out, clk_i, rst_ni, out_valid_o && !out_stall_i, !in_stall_o)
  `ORQA_ASSERT_NEXT(a_insert_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_item_i.cmd == CMD_INSERT, in_stall_o)

endmodule

bind overwrite_ring_queue_with_average orqa_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
